FILE: hw/rtl/gpm_pkg.sv
package gpm_pkg;

  // Character codes that the pattern syntax uses.
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  localparam int unsigned LEN_W = 6;
  localparam int unsigned REQ_W = 2;
  localparam int unsigned IDX_IN_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_LOAD = 2'd0,
    REQ_TEXT = 2'd1,
    REQ_END  = 2'd2
  } req_e;

  // Read offsets relative to the current pattern position.
  typedef enum logic [2:0] {
    OFF_0 = 3'd0,
    OFF_1 = 3'd1,
    OFF_2 = 3'd2,
    OFF_3 = 3'd3,
    OFF_4 = 3'd4
  } rd_off_e;

  typedef enum logic [2:0] {
    POS_HOLD,
    POS_ADV1,
    POS_ADV2,
    POS_ADV4,
    POS_ADV5
  } pos_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TXT_TOK,
    ST_TXT_STAR,
    ST_ALT_FIRST,
    ST_ALT_SECOND,
    ST_ALT_CLOSE,
    ST_END_TOK,
    ST_END_STAR,
    ST_END_PUT
  } state_e;

  typedef struct packed {
    logic    wr_en;
    logic    char_ld;
    rd_off_e rd_off;
    pos_op_e pos_op;
    logic    tok_ld;
    logic    first_ld;
    logic    hit_ld;
    logic    set_fail;
    logic    set_err;
    logic    ok_ld;
    logic    ok_val;
    logic    out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic failed;
    logic byte_zero;
    logic byte_lparen;
    logic byte_rparen;
    logic byte_star;
    logic byte_lower;
    logic ch_eq_tok;
    logic hit;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/greedy_pattern_matcher_top.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_stall_o   req_type_i, pattern_index_i, pattern_char_i,
//                                              text_char_i
// result    out        out_valid_o/out_stall_i matched_o, bad_pattern_o
// config    in         cfg_valid_i/cfg_ready_o cfg_pattern_length_i
//
// A load is taken while idle. A text transaction reads the token and the byte after it; an
// alternation also reads both members and the byte after the second, and a starred letter
// passed over is skipped before the next token is read. An end scans past starred letters
// and stops on anything else. After a failure, text is ignored and an end goes straight to
// the result. The controller issues one registered store read per cycle. Reset clears
// position, flags, length and result slot, not the store; a stalled result holds the next end.
module greedy_pattern_matcher_top
  import gpm_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input transactions.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [REQ_W-1:0]    req_type_i,
  input  logic [IDX_IN_W-1:0] pattern_index_i,
  input  logic [7:0]          pattern_char_i,
  input  logic [7:0]          text_char_i,
  // Result transactions.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                matched_o,
  output logic                bad_pattern_o,
  // Pattern length register.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [LEN_W-1:0]    cfg_pattern_length_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // The length register may be written at any time the block is idle, so the
  // configuration channel never pushes back.
  assign cfg_ready_o = 1'b1;

  // The controller walks the pattern one token at a time, issuing one store
  // read per cycle and deciding on the byte that comes back.
  gpm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // The datapath holds the pattern store, the position, the failure flags and
  // the result register.
  gpm_dp #(
    .PATTERN_DEPTH (PATTERN_DEPTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_len_i       (cfg_pattern_length_i),
    .pattern_index_i (pattern_index_i),
    .pattern_char_i  (pattern_char_i),
    .text_char_i     (text_char_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .matched_o       (matched_o),
    .bad_pattern_o   (bad_pattern_o)
  );

endmodule

FILE: hw/rtl/gpm_dp.sv
module gpm_dp
  import gpm_pkg::*;
#(
  parameter int unsigned PATTERN_DEPTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dp_cmd_t             cmd_i,
  output dp_sts_t             sts_o,
  input  logic                cfg_we_i,
  input  logic [LEN_W-1:0]    cfg_len_i,
  input  logic [IDX_IN_W-1:0] pattern_index_i,
  input  logic [7:0]          pattern_char_i,
  input  logic [7:0]          text_char_i,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic                matched_o,
  output logic                bad_pattern_o
);

  localparam int unsigned POS_W = $clog2(PATTERN_DEPTH + 1);
  localparam int unsigned SUM_W = POS_W + 1;
  localparam int unsigned IDX_W = $clog2(PATTERN_DEPTH);
  localparam int unsigned CMP_W = (POS_W > LEN_W) ? POS_W : LEN_W;

  // Position plus a small step, saturated at the store depth.
  function automatic logic [POS_W-1:0] adv(input logic [POS_W-1:0] p,
                                           input logic [2:0] k);
    logic [SUM_W-1:0] s;
    s = {1'b0, p} + {{(SUM_W-3){1'b0}}, k};
    if (s > SUM_W'(PATTERN_DEPTH)) begin
      adv = POS_W'(PATTERN_DEPTH);
    end else begin
      adv = s[POS_W-1:0];
    end
  endfunction

  logic [7:0]       mem [PATTERN_DEPTH];
  logic [LEN_W-1:0] len_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic             fail_q, err_q, ok_q, hit_q;
  logic [7:0]       ch_q, tok_q, first_q, rd_data_q;
  logic             rd_ok_q;
  logic             out_valid_q, matched_q, bad_q;

  logic [POS_W-1:0] rd_addr;
  logic             rd_ok_d;
  logic [CMP_W-1:0] wr_idx_ext;
  logic             wr_ok;
  logic [7:0]       cur;
  logic             out_free;

  assign rd_addr    = adv(pos_q, cmd_i.rd_off);
  assign rd_ok_d    = (CMP_W'(rd_addr) < CMP_W'(len_q)) &&
                      (CMP_W'(rd_addr) < CMP_W'(PATTERN_DEPTH));
  assign wr_idx_ext = CMP_W'(pattern_index_i);
  assign wr_ok      = wr_idx_ext < CMP_W'(PATTERN_DEPTH);

  // Positions at or past the length or the depth read as end of pattern.
  assign cur      = rd_ok_q ? rd_data_q : CH_NUL;
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en && wr_ok) begin
      mem[wr_idx_ext[IDX_W-1:0]] <= pattern_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr[IDX_W-1:0]];
  end

  always_comb begin
    case (cmd_i.pos_op)
      POS_HOLD: pos_d = pos_q;
      POS_ADV1: pos_d = adv(pos_q, 3'd1);
      POS_ADV2: pos_d = adv(pos_q, 3'd2);
      POS_ADV4: pos_d = adv(pos_q, 3'd4);
      POS_ADV5: pos_d = adv(pos_q, 3'd5);
      default:  pos_d = pos_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pos_q       <= '0;
      fail_q      <= 1'b0;
      err_q       <= 1'b0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_ok_q <= rd_ok_d;
      if (cfg_we_i) begin
        len_q <= cfg_len_i;
      end
      if (cmd_i.out_ld) begin
        pos_q       <= '0;
        fail_q      <= 1'b0;
        err_q       <= 1'b0;
        out_valid_q <= 1'b1;
      end else begin
        pos_q <= pos_d;
        if (cmd_i.set_fail) begin
          fail_q <= 1'b1;
        end
        if (cmd_i.set_err) begin
          err_q <= 1'b1;
        end
        if (!out_stall_i) begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.char_ld) begin
      ch_q <= text_char_i;
    end
    if (cmd_i.tok_ld) begin
      tok_q <= cur;
    end
    if (cmd_i.first_ld) begin
      first_q <= cur;
    end
    if (cmd_i.hit_ld) begin
      hit_q <= (ch_q == first_q) || (ch_q == cur);
    end
    if (cmd_i.ok_ld) begin
      ok_q <= cmd_i.ok_val;
    end
    if (cmd_i.out_ld) begin
      matched_q <= ok_q;
      bad_q     <= err_q;
    end
  end

  always_comb begin
    sts_o.failed      = fail_q;
    sts_o.byte_zero   = (cur == CH_NUL);
    sts_o.byte_lparen = (cur == CH_LPAREN);
    sts_o.byte_rparen = (cur == CH_RPAREN);
    sts_o.byte_star   = (cur == CH_STAR);
    sts_o.byte_lower  = (cur >= CH_LOWER_A) && (cur <= CH_LOWER_Z);
    sts_o.ch_eq_tok   = (ch_q == tok_q);
    sts_o.hit         = hit_q;
    sts_o.out_free    = out_free;
  end

  assign out_valid_o   = out_valid_q;
  assign matched_o     = matched_q;
  assign bad_pattern_o = bad_q;

endmodule

FILE: hw/rtl/gpm_ctrl.sv
module gpm_ctrl
  import gpm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [REQ_W-1:0] req_type_i,
  output logic             in_stall_o,
  input  dp_sts_t          sts_i,
  output dp_cmd_t          cmd_o
);

  state_e state_q, state_d;
  logic   in_acc;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_TEXT: begin
              if (!sts_i.failed) begin
                state_d = ST_TXT_TOK;
              end
            end
            REQ_END: begin
              state_d = sts_i.failed ? ST_END_PUT : ST_END_TOK;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_TXT_TOK: begin
        if (sts_i.byte_lparen) begin
          state_d = ST_ALT_FIRST;
        end else if (sts_i.byte_lower) begin
          state_d = ST_TXT_STAR;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_TXT_STAR: begin
        if (sts_i.byte_star && !sts_i.ch_eq_tok) begin
          state_d = ST_TXT_TOK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_ALT_FIRST:  state_d = ST_ALT_SECOND;
      ST_ALT_SECOND: state_d = ST_ALT_CLOSE;
      ST_ALT_CLOSE:  state_d = ST_IDLE;
      ST_END_TOK: begin
        if (sts_i.byte_lower) begin
          state_d = ST_END_STAR;
        end else begin
          state_d = ST_END_PUT;
        end
      end
      ST_END_STAR: begin
        state_d = sts_i.byte_star ? ST_END_TOK : ST_END_PUT;
      end
      ST_END_PUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd_o = '0;
    cmd_o.rd_off = OFF_0;
    cmd_o.pos_op = POS_HOLD;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (req_e'(req_type_i))
            REQ_LOAD: cmd_o.wr_en = 1'b1;
            REQ_TEXT: cmd_o.char_ld = 1'b1;
            REQ_END: begin
              cmd_o.ok_ld  = 1'b1;
              cmd_o.ok_val = 1'b0;
            end
            default: cmd_o.wr_en = 1'b0;
          endcase
        end
      end
      ST_TXT_TOK: begin
        cmd_o.tok_ld = 1'b1;
        cmd_o.rd_off = OFF_1;
        if (!sts_i.byte_lparen && !sts_i.byte_lower) begin
          cmd_o.set_fail = 1'b1;
          cmd_o.set_err  = !sts_i.byte_zero;
        end
      end
      ST_TXT_STAR: begin
        if (sts_i.byte_star) begin
          if (!sts_i.ch_eq_tok) begin
            cmd_o.pos_op = POS_ADV2;
            cmd_o.rd_off = OFF_2;
          end
        end else if (sts_i.ch_eq_tok) begin
          cmd_o.pos_op = POS_ADV1;
        end else begin
          cmd_o.set_fail = 1'b1;
        end
      end
      ST_ALT_FIRST: begin
        cmd_o.first_ld = 1'b1;
        cmd_o.rd_off   = OFF_3;
      end
      ST_ALT_SECOND: begin
        cmd_o.hit_ld = 1'b1;
        cmd_o.rd_off = OFF_4;
      end
      ST_ALT_CLOSE: begin
        if (sts_i.hit) begin
          cmd_o.pos_op = sts_i.byte_rparen ? POS_ADV5 : POS_ADV4;
        end else begin
          cmd_o.set_fail = 1'b1;
        end
      end
      ST_END_TOK: begin
        cmd_o.rd_off = OFF_1;
        if (!sts_i.byte_lower) begin
          cmd_o.ok_ld   = 1'b1;
          cmd_o.ok_val  = sts_i.byte_zero;
          cmd_o.set_err = !sts_i.byte_zero && !sts_i.byte_lparen;
        end
      end
      ST_END_STAR: begin
        if (sts_i.byte_star) begin
          cmd_o.pos_op = POS_ADV2;
          cmd_o.rd_off = OFF_2;
        end else begin
          cmd_o.ok_ld  = 1'b1;
          cmd_o.ok_val = 1'b0;
        end
      end
      ST_END_PUT: begin
        cmd_o.out_ld = sts_i.out_free;
      end
      default: cmd_o.out_ld = 1'b0;
    endcase
  end

endmodule

FILE: sim/tb_greedy_pattern_matcher_top.sv
module tb_greedy_pattern_matcher_top
  import gpm_pkg::*;
();

  localparam int unsigned DEPTH = 32;
  localparam int unsigned RANDOM_ITEMS = 1850;
  // An end transaction scans at most sixteen starred letters, and a text transaction
  // passes over the same number, so SETTLE_CYCLES covers any busy block.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  // The request code that the block must ignore.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam logic [7:0] CH_BAR = 8'h7C;

  typedef struct packed {
    logic matched;
    logic bad_pattern;
  } verdict_t;

  typedef struct packed {
    logic [REQ_W-1:0]    req;
    logic [IDX_IN_W-1:0] idx;
    logic [7:0]          pch;
    logic [7:0]          tch;
  } xfer_t;

  typedef enum bit {
    ROW_XFER,
    ROW_LEN
  } row_kind_e;

  // One row of the directed table. A row either offers one input transaction or
  // rewrites the pattern length. Where the outcome of an end row is obvious, it is
  // typed in here; every other row takes its expectation from the predictor.
  typedef struct {
    row_kind_e           kind;
    logic [REQ_W-1:0]    req;
    logic [IDX_IN_W-1:0] idx;
    logic [7:0]          pch;
    logic [7:0]          tch;
    bit                  known;
    bit                  exp_matched;
    bit                  exp_bad;
    logic [LEN_W-1:0]    len;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [REQ_W-1:0]    req_type_i;
  logic [IDX_IN_W-1:0] pattern_index_i;
  logic [7:0]          pattern_char_i;
  logic [7:0]          text_char_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                matched_o;
  logic                bad_pattern_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [LEN_W-1:0]    cfg_pattern_length_i;

  greedy_pattern_matcher_top #(
    .PATTERN_DEPTH(DEPTH)
  ) u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .req_type_i          (req_type_i),
    .pattern_index_i     (pattern_index_i),
    .pattern_char_i      (pattern_char_i),
    .text_char_i         (text_char_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .matched_o           (matched_o),
    .bad_pattern_o       (bad_pattern_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_pattern_length_i(cfg_pattern_length_i)
  );

  // Matcher state as this bench sees it. It follows every accepted transaction in
  // order, so it always holds what the block holds.
  logic [7:0]  pat_mem [DEPTH];
  int unsigned pat_len;
  int unsigned match_pos;
  bit          match_failed;
  bit          pattern_bad;

  // Verdicts owed by the block, oldest first.
  verdict_t verdicts_due [$];
  verdict_t oldest;

  dir_row_t    dir_rows [$];
  logic [7:0]  fresh_pat [DEPTH];
  int unsigned pat_fill;
  logic [7:0]  word [$];

  int unsigned burst_left;
  bit          steady_sender;
  bit          hold_request;
  int unsigned cycle_count;
  int unsigned errors;
  int unsigned accepted_items;
  int unsigned load_count;
  int unsigned text_count;
  int unsigned end_count;
  int unsigned verdicts_checked;
  int unsigned long_holds;

  // ---------------------------------------------------------------------------
  // Predictor of the matcher.
  // ---------------------------------------------------------------------------

  // Positions at or past the programmed length, or past the store, read as end.
  function automatic logic [7:0] pat_byte(int unsigned p);
    if (p >= pat_len || p >= DEPTH) begin
      return CH_NUL;
    end
    return pat_mem[p];
  endfunction

  // The position saturates at the store depth, which itself reads as end.
  function automatic int unsigned step_pos(int unsigned p, int unsigned by);
    return (p + by > DEPTH) ? DEPTH : p + by;
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return c >= CH_LOWER_A && c <= CH_LOWER_Z;
  endfunction

  // Match one text byte. A starred letter keeps equal bytes, otherwise it is passed
  // over and the next token gets the byte. Literals and alternations must take it.
  function automatic void consume_text(logic [7:0] ch);
    logic [7:0]  tok;
    logic [7:0]  first;
    logic [7:0]  second;
    int unsigned nxt;
    while (1'b1) begin
      tok = pat_byte(match_pos);
      if (tok == CH_NUL) begin
        match_failed = 1'b1;
        return;
      end
      if (tok == CH_LPAREN) begin
        // Members sit at +1 and +3; the separator byte is never looked at.
        first = pat_byte(step_pos(match_pos, 1));
        second = pat_byte(step_pos(match_pos, 3));
        nxt = step_pos(match_pos, 4);
        if (pat_byte(nxt) == CH_RPAREN) begin
          nxt = step_pos(nxt, 1);
        end
        if (ch == first || ch == second) begin
          match_pos = nxt;
        end else begin
          match_failed = 1'b1;
        end
        return;
      end
      if (!is_letter(tok)) begin
        pattern_bad = 1'b1;
        match_failed = 1'b1;
        return;
      end
      if (pat_byte(step_pos(match_pos, 1)) != CH_STAR) begin
        if (ch == tok) begin
          match_pos = step_pos(match_pos, 1);
        end else begin
          match_failed = 1'b1;
        end
        return;
      end
      if (ch == tok) begin
        return;
      end
      match_pos = step_pos(match_pos, 2);
    end
  endfunction

  // True when only starred letters are left. An unknown byte met on the way marks
  // the pattern bad; an alternation just ends the scan with no match.
  function automatic bit tail_all_stars();
    int unsigned p;
    logic [7:0]  tok;
    p = match_pos;
    while (1'b1) begin
      tok = pat_byte(p);
      if (tok == CH_NUL) begin
        return 1'b1;
      end
      if (!is_letter(tok)) begin
        if (tok != CH_LPAREN) begin
          pattern_bad = 1'b1;
        end
        return 1'b0;
      end
      if (pat_byte(step_pos(p, 1)) != CH_STAR) begin
        return 1'b0;
      end
      p = step_pos(p, 2);
    end
    return 1'b0;
  endfunction

  // Apply one accepted transaction; returns 1 when it owes a verdict.
  function automatic bit predict_verdict(input xfer_t x, output verdict_t v);
    v = '0;
    case (x.req)
      REQ_LOAD: begin
        pat_mem[x.idx] = x.pch;
      end
      REQ_TEXT: begin
        // Once the match has failed, text is ignored until the end of text.
        if (!match_failed) begin
          consume_text(x.tch);
        end
      end
      REQ_END: begin
        v.matched = match_failed ? 1'b0 : tail_all_stars();
        v.bad_pattern = pattern_bad;
        match_pos = 0;
        match_failed = 1'b0;
        pattern_bad = 1'b0;
        return 1'b1;
      end
      default: begin
      end
    endcase
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  function automatic xfer_t mk_xfer(logic [REQ_W-1:0] req, logic [IDX_IN_W-1:0] idx,
                                    logic [7:0] pch, logic [7:0] tch);
    xfer_t x;
    x.req = req;
    x.idx = idx;
    x.pch = pch;
    x.tch = tch;
    return x;
  endfunction

  // Letters come mostly from a small set so that stars and literals collide often.
  function automatic logic [7:0] pick_letter();
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(CH_LOWER_A, CH_LOWER_Z));
    end
    return 8'($urandom_range(CH_LOWER_A, CH_LOWER_A + 2));
  endfunction

  function automatic void put_pat(logic [7:0] b);
    if (pat_fill < DEPTH) begin
      fresh_pat[pat_fill] = b;
      pat_fill++;
    end
  endfunction

  // Fill a whole store image with random tokens. A noisy image also carries unknown
  // bytes and zero bytes; a starred image holds nothing but starred letters.
  function automatic void build_pattern(bit noisy, bit starred);
    int unsigned r;
    logic [7:0]  b;
    pat_fill = 0;
    while (pat_fill < DEPTH) begin
      r = starred ? 50 : $urandom_range(0, noisy ? 99 : 89);
      if (r < 40) begin
        put_pat(pick_letter());
      end else if (r < 70) begin
        put_pat(pick_letter());
        put_pat(CH_STAR);
      end else if (r < 90) begin
        put_pat(CH_LPAREN);
        put_pat(pick_letter());
        put_pat(($urandom_range(0, 7) == 0) ? 8'($urandom) : CH_BAR);
        put_pat(pick_letter());
        if ($urandom_range(0, 9) < 7) begin
          put_pat(CH_RPAREN);
        end
      end else if (r < 97) begin
        b = 8'($urandom);
        if (is_letter(b) || b == CH_LPAREN) begin
          b = CH_STAR;
        end
        put_pat(b);
      end else begin
        put_pat(CH_NUL);
      end
    end
  endfunction

  // Walk the loaded pattern and spell a text that it accepts, then sometimes break
  // that text so that failures show up at every point of a match.
  function automatic void build_word();
    int unsigned p;
    logic [7:0]  tok;
    word.delete();
    p = 0;
    while (p < DEPTH && word.size() < 40) begin
      tok = pat_byte(p);
      if (tok == CH_LPAREN) begin
        word.push_back($urandom_range(0, 1) ? pat_byte(step_pos(p, 1))
                                            : pat_byte(step_pos(p, 3)));
        p = step_pos(p, 4);
        if (pat_byte(p) == CH_RPAREN) begin
          p = step_pos(p, 1);
        end
      end else if (is_letter(tok)) begin
        if (pat_byte(step_pos(p, 1)) == CH_STAR) begin
          repeat ($urandom_range(0, 3)) word.push_back(tok);
          p = step_pos(p, 2);
        end else begin
          word.push_back(tok);
          p = step_pos(p, 1);
        end
      end else begin
        break;
      end
    end
    case ($urandom_range(0, 9))
      0: begin
        if (word.size() != 0) begin
          word[$urandom_range(0, word.size() - 1)] = 8'($urandom);
        end
      end
      1: word.push_back(pick_letter());
      2: begin
        if (word.size() != 0) begin
          void'(word.pop_back());
        end
      end
      3: word.push_front(pick_letter());
      default: begin
      end
    endcase
  endfunction

  // Offer one input transaction and wait until it is taken. The sender works in
  // bursts; between bursts it drops valid for a random gap unless it runs steady.
  // Entered and left at a falling edge.
  task automatic offer(input xfer_t x, input bit known, input verdict_t typed);
    int unsigned gap;
    verdict_t    v;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = steady_sender ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    req_type_i <= x.req;
    pattern_index_i <= x.idx;
    pattern_char_i <= x.pch;
    text_char_i <= x.tch;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (predict_verdict(x, v)) begin
      verdicts_due.push_back(known ? typed : v);
    end
    case (x.req)
      REQ_LOAD: load_count++;
      REQ_TEXT: text_count++;
      REQ_END: end_count++;
      default: begin
      end
    endcase
    if (x.req != REQ_UNUSED) begin
      accepted_items++;
    end
    @(negedge clk_i);
  endtask

  // Stop offering, let every owed verdict arrive, then give the block time to finish
  // any text transaction still at work.
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    while (verdicts_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    burst_left = 0;
  endtask

  task automatic write_pattern_length(input int unsigned len);
    cfg_valid_i <= 1'b1;
    cfg_pattern_length_i <= len[LEN_W-1:0];
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    pat_len = len;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One text: its bytes, with an occasional stray load or ignored request mixed in,
  // then the end of text that asks for the verdict.
  task automatic send_word();
    build_word();
    foreach (word[i]) begin
      if ($urandom_range(0, 39) == 0) begin
        offer(mk_xfer(REQ_LOAD, 5'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
      end
      if ($urandom_range(0, 59) == 0) begin
        offer(mk_xfer(REQ_UNUSED, 5'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
      end
      offer(mk_xfer(REQ_TEXT, 5'($urandom), 8'($urandom), word[i]), 1'b0, '0);
    end
    offer(mk_xfer(REQ_END, 5'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Clock, run limit and result checking.
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached, %0d verdicts still owed", $time,
               CYCLE_LIMIT, verdicts_due.size());
      $display("greedy_pattern_matcher_top test failed");
      $finish;
    end
  end

  // Each result transaction is compared with the oldest owed verdict, field by field.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual matched %0b bad_pattern %0b",
                 $time, matched_o, bad_pattern_o);
        errors++;
      end else begin
        oldest = verdicts_due.pop_front();
        if (matched_o !== oldest.matched) begin
          $display("%0t: matched mismatch, expected %0b, actual %0b", $time,
                   oldest.matched, matched_o);
          errors++;
        end
        if (bad_pattern_o !== oldest.bad_pattern) begin
          $display("%0t: bad_pattern mismatch, expected %0b, actual %0b", $time,
                   oldest.bad_pattern, bad_pattern_o);
          errors++;
        end
        verdicts_checked++;
      end
    end
  end

  // Receiver stall pattern. It switches between no stall, light and heavy random
  // stalls and a periodic stall. On request it holds the output off for a long
  // stretch so that a verdict parks in the output register, a second end of text
  // backs up behind it and the input side stalls.
  initial begin
    int unsigned mode;
    int unsigned mode_left;
    int unsigned period;
    int unsigned tick;
    out_stall_i = 1'b0;
    mode = 0;
    mode_left = 0;
    period = 2;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        long_holds++;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 250);
        period = $urandom_range(2, 5);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 3) != 0);
        default: out_stall_i <= (tick % period == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned phase;
    int unsigned len;
    int unsigned load_n;
    int unsigned random_goal;
    int unsigned len_lo;
    int unsigned len_hi;
    xfer_t       x;
    verdict_t    typed;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = REQ_LOAD;
    pattern_index_i = '0;
    pattern_char_i = '0;
    text_char_i = '0;
    cfg_valid_i = 1'b0;
    cfg_pattern_length_i = '0;
    foreach (pat_mem[i]) pat_mem[i] = CH_NUL;
    pat_len = 0;
    match_pos = 0;
    match_failed = 1'b0;
    pattern_bad = 1'b0;
    burst_left = 0;
    steady_sender = 1'b0;
    hold_request = 1'b0;
    cycle_count = 0;
    errors = 0;
    accepted_items = 0;
    load_count = 0;
    text_count = 0;
    end_count = 0;
    verdicts_checked = 0;
    long_holds = 0;
    len_lo = DEPTH;
    len_hi = 0;

    // After reset the length is zero, so an empty text matches and any text byte
    // runs past the end of the pattern.
    dir_rows.push_back('{ROW_XFER, REQ_END, 5'd0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd31, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_END, 5'd0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b0, 6'd0});
    // Load a*b(c|d) and open it up with a length of eight.
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd0, "a", 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd1, CH_STAR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd2, "b", 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd3, CH_LPAREN, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd4, "c", 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd5, CH_BAR, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd6, "d", 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd7, CH_RPAREN, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_LEN, REQ_LOAD, 5'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 6'd8});
    // "aabd": the star keeps both a's, then b, then the second alternative.
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "a", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "a", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "b", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "d", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_END, 5'd0, 8'h00, 8'h00, 1'b1, 1'b1, 1'b0, 6'd0});
    // A zero byte replaces the closing parenthesis, then the alternation misses and
    // an unused request code is offered in the middle of the failed text.
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd7, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "b", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, "x", 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_UNUSED, 5'd31, 8'hFF, 8'hFF, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_END, 5'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    // An unknown byte at the head of the pattern flags the pattern as bad.
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd0, 8'hFF, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_TEXT, 5'd0, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});
    dir_rows.push_back('{ROW_XFER, REQ_END, 5'd0, 8'h00, 8'h00, 1'b1, 1'b0, 1'b1, 6'd0});
    // The top store entry, out of reach of the current length.
    dir_rows.push_back('{ROW_XFER, REQ_LOAD, 5'd31, "z", 8'h00, 1'b0, 1'b0, 1'b0, 6'd0});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_LEN) begin
        settle_idle();
        write_pattern_length(dir_rows[i].len);
      end else begin
        x = mk_xfer(dir_rows[i].req, dir_rows[i].idx, dir_rows[i].pch, dir_rows[i].tch);
        typed.matched = dir_rows[i].exp_matched;
        typed.bad_pattern = dir_rows[i].exp_bad;
        offer(x, dir_rows[i].known, typed);
      end
    end

    // Random part. Every setup waits for all owed verdicts, sets a length, loads a
    // fresh pattern and streams texts built from it. The first setup loads the whole
    // store, so no entry is ever read before it has been written.
    random_goal = accepted_items + RANDOM_ITEMS;
    phase = 0;
    while (accepted_items < random_goal) begin
      settle_idle();
      steady_sender = ($urandom_range(0, 3) == 0);
      case (phase)
        0: len = DEPTH;
        1: len = 0;
        2: len = 1;
        default: begin
          case ($urandom_range(0, 9))
            0: len = 0;
            1: len = DEPTH;
            default: len = $urandom_range(1, DEPTH);
          endcase
        end
      endcase
      if (len < len_lo) len_lo = len;
      if (len > len_hi) len_hi = len;
      write_pattern_length(len);
      build_pattern($urandom_range(0, 3) == 0, phase == 0 || phase % 7 == 3);
      load_n = (phase == 0) ? DEPTH : len;
      for (int unsigned k = 0; k < load_n; k++) begin
        offer(mk_xfer(REQ_LOAD, k[IDX_IN_W-1:0], fresh_pat[k], 8'($urandom)), 1'b0, '0);
      end
      if (phase == 3 || phase % 16 == 9) begin
        hold_request = 1'b1;
      end
      repeat ($urandom_range(4, 12)) send_word();
      phase++;
    end

    settle_idle();

    $display("Covered %0d loads, %0d text bytes and %0d ends over %0d pattern setups,",
             load_count, text_count, end_count, phase);
    $display("lengths %0d to %0d; checked %0d verdicts with %0d long output holds, %0d mismatches.",
             len_lo, len_hi, verdicts_checked, long_holds, errors);
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("greedy_pattern_matcher_top test passed");
    end else begin
      $display("greedy_pattern_matcher_top test failed");
    end
    $finish;
  end

endmodule

FILE: greedy_pattern_matcher_top.f
hw/rtl/gpm_pkg.sv
hw/rtl/gpm_dp.sv
hw/rtl/gpm_ctrl.sv
hw/rtl/greedy_pattern_matcher_top.sv
sim/tb_greedy_pattern_matcher_top.sv
